FILE: hdl/c4sm_pkg.sv
// shared types and constants for the c4fm symbol median timing assist
`default_nettype none

package c4sm_pkg;

  localparam int unsigned SamplesPerSymbol = 5;
  localparam int unsigned SampleW          = 16;
  localparam int unsigned CfgIndexW        = 4;
  localparam int unsigned RunToNudge       = 4;
  localparam int unsigned CooldownSymbols  = 12;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [SamplesPerSymbol-1:0][SampleW-1:0] window_t;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] RegTedMode      = 4'd0;
  localparam logic [CfgIndexW-1:0] RegCenterLevel  = 4'd1;
  localparam logic [CfgIndexW-1:0] RegMinReference = 4'd2;
  localparam logic [CfgIndexW-1:0] RegMaxReference = 4'd3;

  typedef enum logic [1:0] {
    TED_OFF        = 2'd0,
    TED_EARLY_LATE = 2'd1,
    TED_MM         = 2'd2
  } ted_mode_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd3
  } dir_e;

  typedef struct packed {
    ted_mode_e mode;
    sample_t   center_level;
    sample_t   min_reference;
    sample_t   max_reference;
  } ted_cfg_t;

endpackage

`default_nettype wire

FILE: hdl/c4sm_median5.sv
// median of five samples through a seven compare-exchange network
`default_nettype none

module c4sm_median5 (
  input  wire c4sm_pkg::window_t win_i,
  output c4sm_pkg::sample_t      median_o
);

  c4sm_pkg::sample_t a0, b0, c0, d0, e0;
  c4sm_pkg::sample_t a1, b1, d1, e1;
  c4sm_pkg::sample_t a2, d2;
  c4sm_pkg::sample_t b3, e3;
  c4sm_pkg::sample_t b4, c4;
  c4sm_pkg::sample_t c5, d5;
  c4sm_pkg::sample_t b6, c6;

  always_comb begin
    a0 = c4sm_pkg::sample_t'(win_i[0]);
    b0 = c4sm_pkg::sample_t'(win_i[1]);
    c0 = c4sm_pkg::sample_t'(win_i[2]);
    d0 = c4sm_pkg::sample_t'(win_i[3]);
    e0 = c4sm_pkg::sample_t'(win_i[4]);
    // (a,b) and (d,e)
    a1 = (a0 > b0) ? b0 : a0;
    b1 = (a0 > b0) ? a0 : b0;
    d1 = (d0 > e0) ? e0 : d0;
    e1 = (d0 > e0) ? d0 : e0;
    // (a,d)
    a2 = (a1 > d1) ? d1 : a1;
    d2 = (a1 > d1) ? a1 : d1;
    // (b,e)
    b3 = (b1 > e1) ? e1 : b1;
    e3 = (b1 > e1) ? b1 : e1;
    // (b,c)
    b4 = (b3 > c0) ? c0 : b3;
    c4 = (b3 > c0) ? b3 : c0;
    // (c,d)
    c5 = (c4 > d2) ? d2 : c4;
    d5 = (c4 > d2) ? c4 : d2;
    // (b,c)
    b6 = (b4 > c5) ? c5 : b4;
    c6 = (b4 > c5) ? b4 : c5;
  end

  assign median_o = c6;

  // the minimum and maximum of a, b, d, e and the other losers fall out of the network unused
  logic unused_ok;
  assign unused_ok = ^{a2, e3, d5, b6};

endmodule

`default_nettype wire

FILE: hdl/c4sm_ted.sv
// timing error detector and sampling center tracking
`default_nettype none

module c4sm_ted (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      step_i,
  input  wire c4sm_pkg::window_t   win_i,
  input  wire c4sm_pkg::ted_cfg_t  cfg_i,
  output logic [1:0]               center_d_o,
  output logic [15:0]              nudge_d_o
);

  logic [1:0]          center_q, center_d;
  logic                dec_seen_q, dec_seen_d;
  c4sm_pkg::dir_e      run_dir_q, run_dir_d;
  logic [2:0]          run_len_q, run_len_d;
  logic [3:0]          cool_q, cool_d;
  logic [15:0]         nudge_q, nudge_d;

  c4sm_pkg::sample_t   early, mid, late;
  logic                center_ok;
  logic signed [16:0]  early_x, late_x, abs_e, abs_l;
  logic signed [16:0]  mid2, top_thr;
  logic                ak_pos;
  c4sm_pkg::dir_e      dir, ds;
  logic                run;
  logic [2:0]          len_next;

  // early / mid / late taps around the center
  always_comb begin
    center_ok = 1'b1;
    early     = c4sm_pkg::sample_t'(win_i[1]);
    mid       = c4sm_pkg::sample_t'(win_i[2]);
    late      = c4sm_pkg::sample_t'(win_i[3]);
    case (center_q)
      2'd1: begin
        early = c4sm_pkg::sample_t'(win_i[0]);
        mid   = c4sm_pkg::sample_t'(win_i[1]);
        late  = c4sm_pkg::sample_t'(win_i[2]);
      end
      2'd2: begin
        early = c4sm_pkg::sample_t'(win_i[1]);
        mid   = c4sm_pkg::sample_t'(win_i[2]);
        late  = c4sm_pkg::sample_t'(win_i[3]);
      end
      2'd3: begin
        early = c4sm_pkg::sample_t'(win_i[2]);
        mid   = c4sm_pkg::sample_t'(win_i[3]);
        late  = c4sm_pkg::sample_t'(win_i[4]);
      end
      default: center_ok = 1'b0;
    endcase
  end

  // magnitudes and slicer sign
  always_comb begin
    early_x = {early[15], early};
    late_x  = {late[15], late};
    abs_e   = early[15] ? -early_x : early_x;
    abs_l   = late[15] ? -late_x : late_x;
    mid2    = {mid, 1'b0};
    top_thr = {cfg_i.max_reference[15], cfg_i.max_reference}
            + {cfg_i.center_level[15], cfg_i.center_level};
    // decision is +1 or +3
    ak_pos  = (mid2 >= top_thr) || (mid >= cfg_i.center_level);
    if (late > early) begin
      ds = c4sm_pkg::DIR_UP;
    end else if (late < early) begin
      ds = c4sm_pkg::DIR_DOWN;
    end else begin
      ds = c4sm_pkg::DIR_NONE;
    end
  end

  always_comb begin
    center_d   = center_q;
    dec_seen_d = dec_seen_q;
    run_dir_d  = run_dir_q;
    run_len_d  = run_len_q;
    cool_d     = cool_q;
    nudge_d    = nudge_q;
    run        = 1'b0;
    dir        = c4sm_pkg::DIR_NONE;
    len_next   = run_len_q;

    if (step_i && center_ok) begin
      case (cfg_i.mode)
        c4sm_pkg::TED_EARLY_LATE: begin
          run = 1'b1;
          if (abs_l > abs_e) begin
            dir = c4sm_pkg::DIR_UP;
          end else if (abs_l < abs_e) begin
            dir = c4sm_pkg::DIR_DOWN;
          end else begin
            dir = c4sm_pkg::DIR_NONE;
          end
        end
        c4sm_pkg::TED_MM: begin
          dec_seen_d = 1'b1;
          // first decision only primes the detector
          run = dec_seen_q;
          if (ak_pos || ds == c4sm_pkg::DIR_NONE) begin
            dir = ds;
          end else if (ds == c4sm_pkg::DIR_UP) begin
            dir = c4sm_pkg::DIR_DOWN;
          end else begin
            dir = c4sm_pkg::DIR_UP;
          end
        end
        default: run = 1'b0;
      endcase
    end

    if (run) begin
      if (dir == c4sm_pkg::DIR_NONE) begin
        run_dir_d = c4sm_pkg::DIR_NONE;
        run_len_d = 3'd0;
      end else if (cool_q != 4'd0) begin
        cool_d = cool_q - 4'd1;
      end else begin
        if (dir == run_dir_q) begin
          len_next = run_len_q + 3'd1;
        end else begin
          len_next = 3'd1;
        end
        run_dir_d = dir;
        run_len_d = len_next;
        if (len_next >= 3'(c4sm_pkg::RunToNudge)) begin
          if (dir == c4sm_pkg::DIR_UP && center_q != 2'd3) begin
            center_d = center_q + 2'd1;
            nudge_d  = nudge_q + 16'd1;
          end else if (dir == c4sm_pkg::DIR_DOWN && center_q != 2'd1) begin
            center_d = center_q - 2'd1;
            nudge_d  = nudge_q + 16'd1;
          end
          cool_d    = 4'(c4sm_pkg::CooldownSymbols);
          run_len_d = 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q   <= 2'd2;
      dec_seen_q <= 1'b0;
      run_dir_q  <= c4sm_pkg::DIR_NONE;
      run_len_q  <= 3'd0;
      cool_q     <= 4'd0;
      nudge_q    <= 16'd0;
    end else begin
      center_q   <= center_d;
      dec_seen_q <= dec_seen_d;
      run_dir_q  <= run_dir_d;
      run_len_q  <= run_len_d;
      cool_q     <= cool_d;
      nudge_q    <= nudge_d;
    end
  end

  assign center_d_o = center_d;
  assign nudge_d_o  = nudge_d;

endmodule

`default_nettype wire

FILE: hdl/c4fm_symbol_median_timing_assist.sv
// top level: c4fm symbol median with early-late / mueller-muller timing assist
//
// usage
//   input channel: in_valid_i / in_stall_o carry one five-sample window
//   (sample_0_i..sample_4_i) plus in_sync_i; a request is taken at a rising
//   edge with valid high and stall low
//   output channel: out_valid_o / out_stall_i carry the median, the sampling
//   center after the step and the running nudge count
//   config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_wdata_i; ready is always high, indexes above three are dropped
//   a taken request moves from the input register to the result register when the output stage can take it
//   throughput: one request per cycle while the receiver does not stall,
//   limited only by the single register loop through the center tap
//   select, the detector compare and the run / cooldown update
//   reset: asynchronous, active low; both stages empty, center at 2,
//   detector off, all references zero, nudge count zero
//   stall: a stalled result holds in the output register; the input
//   register still takes a request while the output stage is free, and
//   in_stall_o rises only when both stages are full and the receiver stalls
`default_nettype none

module c4fm_symbol_median_timing_assist (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input requests
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [15:0] sample_0_i,
  input  wire  [15:0] sample_1_i,
  input  wire  [15:0] sample_2_i,
  input  wire  [15:0] sample_3_i,
  input  wire  [15:0] sample_4_i,
  input  wire         in_sync_i,
  // results
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [15:0] symbol_value_o,
  output logic [1:0]  sampling_center_o,
  output logic [15:0] nudges_total_o,
  // configuration writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [3:0]  cfg_index_i,
  input  wire  [15:0] cfg_wdata_i
);

  // configuration registers
  c4sm_pkg::ted_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= c4sm_pkg::TED_OFF;
      cfg_q.center_level  <= '0;
      cfg_q.min_reference <= '0;
      cfg_q.max_reference <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        c4sm_pkg::RegTedMode:      cfg_q.mode <= c4sm_pkg::ted_mode_e'(cfg_wdata_i[1:0]);
        c4sm_pkg::RegCenterLevel:  cfg_q.center_level  <= cfg_wdata_i;
        c4sm_pkg::RegMinReference: cfg_q.min_reference <= cfg_wdata_i;
        c4sm_pkg::RegMaxReference: cfg_q.max_reference <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // input register stage
  logic              in_valid_q, in_valid_d;
  c4sm_pkg::window_t win_q;
  logic              sync_q;
  logic              advance, load_in;

  // output stage can take a new result when empty or draining
  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign load_in    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (load_in) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      win_q  <= {sample_4_i, sample_3_i, sample_2_i, sample_1_i, sample_0_i};
      sync_q <= in_sync_i;
    end
  end

  // median and timing logic between the two registers
  c4sm_pkg::sample_t median;
  logic [1:0]        center_d;
  logic [15:0]       nudge_d;
  logic              step;

  // the detector state moves only when a request with in_sync_i low crosses into the output stage
  assign step = advance && in_valid_q && !sync_q;

  c4sm_median5 u_median (
    .win_i    (win_q),
    .median_o (median)
  );

  c4sm_ted u_ted (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .win_i      (win_q),
    .cfg_i      (cfg_q),
    .center_d_o (center_d),
    .nudge_d_o  (nudge_d)
  );

  // result register
  logic        out_valid_q;
  logic [15:0] symbol_value_q;
  logic [1:0]  center_q;
  logic [15:0] nudges_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      symbol_value_q <= median;
      center_q       <= center_d;
      nudges_q       <= nudge_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign symbol_value_o    = symbol_value_q;
  assign sampling_center_o = center_q;
  assign nudges_total_o    = nudges_q;

endmodule

`default_nettype wire
